// File: hdl/checked_frame_deframer_assert.svh
// assertion macros for the checked frame deframer checker
`ifndef CHECKED_FRAME_DEFRAMER_ASSERT_SVH
`define CHECKED_FRAME_DEFRAMER_ASSERT_SVH

// antecedent holds -> consequent holds in the same cycle
`define CFD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cfd check failed");

// antecedent holds -> consequent holds in the next cycle
`define CFD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cfd check failed");

`endif

// File: hdl/cfd_pkg.sv
// shared types, constants and hash step for the checked frame deframer
`default_nettype none
package cfd_pkg;
    localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;

    localparam logic [4:0] POS_MAGIC   = 5'd3;
    localparam logic [4:0] POS_VERSION = 5'd4;
    localparam logic [4:0] POS_TYPE    = 5'd5;
    localparam logic [4:0] POS_FLAGS   = 5'd7;
    localparam logic [4:0] POS_LENGTH  = 5'd11;
    localparam logic [4:0] POS_DIGEST  = 5'd12;
    localparam logic [4:0] POS_LAST    = 5'd19;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_CORRUPT = 3'd1;
    localparam logic [2:0] ST_VERSION = 3'd2;
    localparam logic [2:0] ST_TYPE    = 3'd3;
    localparam logic [2:0] ST_SIZE    = 3'd4;

    localparam logic [2:0] REG_MAGIC   = 3'd0;
    localparam logic [2:0] REG_VERSION = 3'd1;
    localparam logic [2:0] REG_TYPE_LO = 3'd2;
    localparam logic [2:0] REG_TYPE_HI = 3'd3;
    localparam logic [2:0] REG_LIMIT   = 3'd4;

    typedef struct packed {
        logic        is_payload;
        logic [7:0]  data;
        logic [7:0]  kind;
        logic [31:0] length;
        logic        end_mark;
        logic        check_hash;
        logic [2:0]  status;
        logic [63:0] expected;
    } t_cmd;

    // fnv-1a 64 step, prime is 2^40 + 0x1b3
    function automatic logic [63:0] fnv_step(input logic [63:0] d, input logic [7:0] b);
        logic [63:0] x;
        x = d ^ {56'd0, b};
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction
endpackage
`default_nettype wire

// File: hdl/cfd_front.sv
// header parser and payload classifier with configuration registers
`default_nettype none
module cfd_front import cfd_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_accept,
    input  wire logic [7:0]  i_byte,
    output t_cmd             o_cmd,
    output logic             o_push
);
    logic [31:0] r_magic, r_limit;
    logic [7:0]  r_version, r_type_lo, r_type_hi;
    logic [4:0]  r_pos, n_pos;
    logic        r_in_pay, n_in_pay;
    logic [31:0] r_shift, n_shift, r_len, n_len, r_left, n_left;
    logic [7:0]  r_type, n_type;
    logic [63:0] r_exp, n_exp;
    logic        fail;
    logic [2:0]  fail_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic   <= '0;
            r_version <= '0;
            r_type_lo <= '0;
            r_type_hi <= 8'd7;
            r_limit   <= 32'd65536;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_MAGIC:   r_magic   <= i_cfg_data;
                REG_VERSION: r_version <= i_cfg_data[7:0];
                REG_TYPE_LO: r_type_lo <= i_cfg_data[7:0];
                REG_TYPE_HI: r_type_hi <= i_cfg_data[7:0];
                REG_LIMIT:   r_limit   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_pos    = r_pos;
        n_in_pay = r_in_pay;
        n_shift  = r_shift;
        n_len    = r_len;
        n_left   = r_left;
        n_type   = r_type;
        n_exp    = r_exp;
        fail     = 1'b0;
        fail_st  = ST_OK;
        o_push   = 1'b0;
        o_cmd    = '0;
        if (r_in_pay) begin
            n_left = r_left - 32'd1;
            o_push = 1'b1;
            o_cmd.is_payload = 1'b1;
            o_cmd.data       = i_byte;
            o_cmd.end_mark   = (n_left == 32'd0);
            o_cmd.check_hash = (n_left == 32'd0);
            if (n_left == 32'd0) begin
                n_in_pay = 1'b0;
                n_pos    = '0;
            end
        end else begin
            if (r_pos == 5'd0) begin
                n_type  = '0;
                n_len   = '0;
                n_shift = '0;
                n_exp   = '0;
            end
            n_shift = {i_byte, n_shift[31:8]};
            n_pos   = r_pos + 5'd1;
            case (r_pos)
                POS_MAGIC: begin
                    if (n_shift != r_magic) begin fail = 1'b1; fail_st = ST_CORRUPT; end
                end
                POS_VERSION: begin
                    if (i_byte != r_version) begin fail = 1'b1; fail_st = ST_VERSION; end
                end
                POS_TYPE: begin
                    n_type = i_byte;
                    if (i_byte < r_type_lo || i_byte > r_type_hi) begin
                        fail = 1'b1; fail_st = ST_TYPE;
                    end
                end
                POS_FLAGS: begin
                    if (n_shift[31:16] != 16'd0) begin fail = 1'b1; fail_st = ST_TYPE; end
                end
                POS_LENGTH: begin
                    n_len = n_shift;
                    if (n_shift > r_limit) begin fail = 1'b1; fail_st = ST_SIZE; end
                end
                default: ;
            endcase
            if (fail) begin
                n_pos          = '0;
                o_push         = 1'b1;
                o_cmd.end_mark = 1'b1;
                o_cmd.status   = fail_st;
            end else begin
                if (r_pos >= POS_DIGEST) n_exp = {i_byte, n_exp[63:8]};
                if (r_pos >= POS_LAST) begin
                    n_pos = '0;
                    if (n_len == 32'd0) begin
                        // empty payload: verdict against the basis
                        o_push           = 1'b1;
                        o_cmd.end_mark   = 1'b1;
                        o_cmd.check_hash = 1'b1;
                    end else begin
                        n_left   = n_len;
                        n_in_pay = 1'b1;
                    end
                end
            end
        end
        o_cmd.kind     = n_type;
        o_cmd.length   = n_len;
        o_cmd.expected = n_exp;
        if (!i_accept) o_push = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_in_pay <= 1'b0;
            r_shift  <= '0;
            r_len    <= '0;
            r_left   <= '0;
            r_type   <= '0;
            r_exp    <= '0;
        end else if (i_accept) begin
            r_pos    <= n_pos;
            r_in_pay <= n_in_pay;
            r_shift  <= n_shift;
            r_len    <= n_len;
            r_left   <= n_left;
            r_type   <= n_type;
            r_exp    <= n_exp;
        end
    end
endmodule
`default_nettype wire

// File: hdl/cfd_queue.sv
// two-entry command queue between front and back
`default_nettype none
module cfd_queue import cfd_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_cmd      i_cmd,
    output logic      o_full,
    output logic      o_valid,
    input  wire logic i_pop,
    output t_cmd      o_cmd
);
    t_cmd       r_mem [2];
    logic       r_wr, r_rd;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= ~r_wr;
            if (i_pop)  r_rd <= ~r_rd;
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end
endmodule
`default_nettype wire

// File: hdl/cfd_back.sv
// running hash, verdict and output register
`default_nettype none
module cfd_back import cfd_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_valid,
    input  t_cmd        i_cmd,
    output logic        o_pop,
    input  wire logic   i_out_stall,
    output logic        o_out_valid,
    output logic        o_is_payload,
    output logic [7:0]  o_data_out,
    output logic [7:0]  o_frame_kind,
    output logic [31:0] o_frame_length,
    output logic        o_end_mark,
    output logic [2:0]  o_status
);
    logic [63:0] r_digest, n_digest, cmp;

    assign o_pop = i_valid && (!o_out_valid || !i_out_stall);
    assign n_digest = fnv_step(r_digest, i_cmd.data);
    assign cmp = i_cmd.is_payload ? n_digest : r_digest;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digest    <= FNV_BASIS;
            o_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                o_out_valid <= 1'b1;
                if (i_cmd.is_payload) r_digest <= i_cmd.end_mark ? FNV_BASIS : n_digest;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            o_is_payload   <= i_cmd.is_payload;
            o_data_out     <= i_cmd.data;
            o_frame_kind   <= i_cmd.kind;
            o_frame_length <= i_cmd.length;
            o_end_mark     <= i_cmd.end_mark;
            if (i_cmd.check_hash) o_status <= (cmp == i_cmd.expected) ? ST_OK : ST_CORRUPT;
            else                  o_status <= i_cmd.status;
        end
    end
endmodule
`default_nettype wire

// File: hdl/checked_frame_deframer.sv
// top level of the checked frame deframer
// channel | dir | handshake                   | payload
// in      | in  | i_in_valid / o_in_stall     | i_stream_byte
// out     | out | o_out_valid / i_out_stall   | is_payload, data_out, kind, length, end, status
// cfg     | in  | i_cfg_we                    | i_cfg_index, i_cfg_data
// one byte per cycle while o_in_stall is low; results pass the queue, then the output register
// header bytes give no result unless one fails or ends an empty frame; hashing is in the back part
// stall on the output fills the two-entry queue, then o_in_stall rises
// synchronous active-low reset clears parser state, queue and output valid
`default_nettype none
module checked_frame_deframer import cfd_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_stream_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_is_payload,
    output logic [7:0]       o_data_out,
    output logic [7:0]       o_frame_kind,
    output logic [31:0]      o_frame_length,
    output logic             o_end_mark,
    output logic [2:0]       o_status
);
    t_cmd f_cmd, q_cmd;
    logic f_push, q_full, q_valid, b_pop, accept;

    assign o_in_stall = q_full;
    assign accept     = i_in_valid && !q_full;

    cfd_front u_front (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_accept(accept), .i_byte(i_stream_byte), .o_cmd(f_cmd), .o_push(f_push)
    );

    cfd_queue u_queue (
        .i_clk, .i_rst_n, .i_push(f_push), .i_cmd(f_cmd), .o_full(q_full),
        .o_valid(q_valid), .i_pop(b_pop), .o_cmd(q_cmd)
    );

    cfd_back u_back (
        .i_clk, .i_rst_n, .i_valid(q_valid), .i_cmd(q_cmd), .o_pop(b_pop),
        .i_out_stall, .o_out_valid, .o_is_payload, .o_data_out, .o_frame_kind,
        .o_frame_length, .o_end_mark, .o_status
    );
endmodule
`default_nettype wire

// File: hdl/cfd_checker.sv
// port-level checker for the checked frame deframer, with its bind
`default_nettype none
`include "checked_frame_deframer_assert.svh"
module cfd_checker import cfd_pkg::*; (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic        o_is_payload,
    input wire logic [7:0]  o_data_out,
    input wire logic        o_end_mark,
    input wire logic [2:0]  o_status
);
    `CFD_ASSERT_NEXT(a_hold_valid, o_out_valid && i_out_stall, o_out_valid)
    `CFD_ASSERT_NEXT(a_hold_data, o_out_valid && i_out_stall, $stable(o_data_out))
    `CFD_ASSERT_NOW(a_hdr_final, o_out_valid && !o_is_payload, o_end_mark)
    `CFD_ASSERT_NOW(a_mid_ok, o_out_valid && !o_end_mark, o_status == ST_OK)
    `CFD_ASSERT_NOW(a_hdr_zero, o_out_valid && !o_is_payload, o_data_out == 8'd0)
endmodule

bind checked_frame_deframer cfd_checker u_cfd_checker (.*);
`default_nettype wire

// File: verif/checked_frame_deframer_test.sv
// self-checking testbench for the checked frame deframer
`timescale 1ns / 100ps
`default_nettype none
module checked_frame_deframer_test;
    import cfd_pkg::*;

    localparam logic [63:0] HASH_SEED  = 64'hcbf29ce484222325;
    localparam logic [63:0] HASH_PRIME = 64'h100000001b3;
    localparam int          HOLD_CYCLES = 300;

    typedef struct {
        logic        is_payload;
        logic [7:0]  data;
        logic [7:0]  kind;
        logic [31:0] length;
        logic        end_mark;
        logic [2:0]  status;
    } t_frame_result;

    typedef enum {
        F_GOOD, F_HASH, F_MAGIC, F_VERSION, F_TYPE, F_FLAGS, F_SIZE, F_NOISE
    } t_flaw;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_stream_byte = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_is_payload;
    logic [7:0]  o_data_out;
    logic [7:0]  o_frame_kind;
    logic [31:0] o_frame_length;
    logic        o_end_mark;
    logic [2:0]  o_status;

    checked_frame_deframer dut (.*);

    always #2 i_clk = ~i_clk;

    // predictor copy of the registers
    logic [31:0] cfg_magic = 32'd0;
    logic [7:0]  cfg_version = 8'd0;
    logic [7:0]  cfg_type_lo = 8'd0;
    logic [7:0]  cfg_type_hi = 8'd7;
    logic [31:0] cfg_limit = 32'd65536;

    // predictor parse state
    logic [4:0]  hdr_pos = '0;
    logic        in_body = 1'b0;
    logic [31:0] hdr_shift = '0;
    logic [7:0]  cur_kind = '0;
    logic [31:0] cur_len = '0;
    logic [31:0] body_left = '0;
    logic [63:0] want_digest = '0;
    logic [63:0] run_digest = HASH_SEED;

    logic [7:0]    pending_bytes[$];
    t_frame_result expected_results[$];
    int            mismatches = 0;
    int            send_gap = 0;
    int            recv_gap = 0;
    bit            calm = 1'b0;
    int            hold_requests = 0;
    int            holds_served = 0;
    int            hold_left = 0;

    function automatic logic [63:0] hash_byte(input logic [63:0] h, input logic [7:0] b);
        return (h ^ {56'd0, b}) * HASH_PRIME;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic add_result(input logic pay, input logic [7:0] d, input logic fin,
                              input logic [2:0] st);
        t_frame_result r;
        r.is_payload = pay;
        r.data = d;
        r.kind = cur_kind;
        r.length = cur_len;
        r.end_mark = fin;
        r.status = st;
        expected_results = {expected_results, r};
    endtask

    task automatic predict_byte(input logic [7:0] b);
        logic [4:0] pos;
        logic       bad;
        logic [2:0] st;
        bad = 1'b0;
        st = ST_OK;
        if (in_body) begin
            run_digest = hash_byte(run_digest, b);
            body_left = body_left - 1;
            if (body_left == 0) begin
                in_body = 1'b0;
                hdr_pos = '0;
                add_result(1'b1, b, 1'b1, run_digest == want_digest ? ST_OK : ST_CORRUPT);
            end else begin
                add_result(1'b1, b, 1'b0, ST_OK);
            end
        end else begin
            pos = hdr_pos;
            if (pos == 0) begin
                cur_kind = '0;
                cur_len = '0;
                hdr_shift = '0;
                want_digest = '0;
            end
            hdr_shift = {b, hdr_shift[31:8]};
            hdr_pos = pos + 1;
            case (pos)
                POS_MAGIC: begin
                    if (hdr_shift != cfg_magic) begin bad = 1'b1; st = ST_CORRUPT; end
                end
                POS_VERSION: begin
                    if (b != cfg_version) begin bad = 1'b1; st = ST_VERSION; end
                end
                POS_TYPE: begin
                    cur_kind = b;
                    if (b < cfg_type_lo || b > cfg_type_hi) begin bad = 1'b1; st = ST_TYPE; end
                end
                POS_FLAGS: begin
                    if (hdr_shift[31:16] != 0) begin bad = 1'b1; st = ST_TYPE; end
                end
                POS_LENGTH: begin
                    cur_len = hdr_shift;
                    if (cur_len > cfg_limit) begin bad = 1'b1; st = ST_SIZE; end
                end
                default: ;
            endcase
            if (bad) begin
                add_result(1'b0, 8'd0, 1'b1, st);
                hdr_pos = '0;
                in_body = 1'b0;
            end else begin
                if (pos >= POS_DIGEST) want_digest = {b, want_digest[63:8]};
                if (pos >= POS_LAST) begin
                    hdr_pos = '0;
                    run_digest = HASH_SEED;
                    if (cur_len == 0) begin
                        add_result(1'b0, 8'd0, 1'b1,
                                   run_digest == want_digest ? ST_OK : ST_CORRUPT);
                    end else begin
                        body_left = cur_len;
                        in_body = 1'b1;
                    end
                end
            end
        end
    endtask

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    // driver: one word per accepted handshake
    always @(posedge i_clk) begin
        logic       nv;
        logic [7:0] nb;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            nv = i_in_valid;
            nb = i_stream_byte;
            if (i_in_valid && !o_in_stall) begin
                predict_byte(i_stream_byte);
                nv = 1'b0;
            end
            if (!nv) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_bytes.size() > 0) begin
                    nb = pending_bytes.pop_front();
                    nv = 1'b1;
                    if (!calm) send_gap = gap_len();
                end
            end
            i_in_valid <= nv;
            i_stream_byte <= nb;
        end
    end

    // monitor and receiver stall
    always @(posedge i_clk) begin
        t_frame_result w;
        logic          ns;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    report("unexpected word", o_data_out, 0);
                end else begin
                    w = expected_results.pop_front();
                    if (o_is_payload !== w.is_payload) report("is_payload", o_is_payload, w.is_payload);
                    if (o_data_out !== w.data) report("data_out", o_data_out, w.data);
                    if (o_frame_kind !== w.kind) report("frame_kind", o_frame_kind, w.kind);
                    if (o_frame_length !== w.length)
                        report("frame_length", o_frame_length, w.length);
                    if (o_end_mark !== w.end_mark) report("end_mark", o_end_mark, w.end_mark);
                    if (o_status !== w.status) report("status", o_status, w.status);
                end
            end
            if (holds_served != hold_requests) begin
                holds_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                ns = 1'b1;
            end else if (recv_gap > 0) begin
                recv_gap--;
                ns = 1'b1;
            end else begin
                ns = 1'b0;
                if (!calm) recv_gap = gap_len();
            end
            i_out_stall <= ns;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_MAGIC:   cfg_magic = val;
            REG_VERSION: cfg_version = val[7:0];
            REG_TYPE_LO: cfg_type_lo = val[7:0];
            REG_TYPE_HI: cfg_type_hi = val[7:0];
            REG_LIMIT:   cfg_limit = val;
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_bytes.size() != 0 || i_in_valid || expected_results.size() != 0);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic make_frame(input t_flaw flaw, input int plen);
        logic [7:0]  hdr[20];
        logic [7:0]  body[$];
        logic [63:0] h;
        logic [31:0] len;
        logic [15:0] flags;
        logic [31:0] magic;
        logic [7:0]  ver;
        logic [7:0]  kind;
        int          upto;
        t_flaw       f;
        f = flaw;
        if (f == F_TYPE && cfg_type_lo == 0 && cfg_type_hi == 8'hff) f = F_FLAGS;
        if (f == F_SIZE && cfg_limit == 32'hffffffff) f = F_HASH;
        if (f == F_NOISE) begin
            repeat (4 * $urandom_range(1, 2))
                pending_bytes = {pending_bytes, 8'($urandom_range(0, 255))};
            return;
        end
        len = (plen > cfg_limit) ? cfg_limit : plen;
        if (f == F_SIZE) len = (cfg_limit < 48 || $urandom_range(0, 1)) ? cfg_limit + 1
                                                                      : $urandom_range(0, 32'hffffffff);
        if (len <= cfg_limit && f == F_SIZE) len = cfg_limit + 1;
        magic = cfg_magic;
        if (f == F_MAGIC) magic = magic ^ (32'd1 << $urandom_range(0, 31));
        ver = cfg_version;
        if (f == F_VERSION) ver = ver ^ (8'd1 << $urandom_range(0, 7));
        if (cfg_type_lo <= cfg_type_hi) kind = $urandom_range(cfg_type_lo, cfg_type_hi);
        else kind = $urandom_range(0, 255);
        if (f == F_TYPE) begin
            do kind = $urandom_range(0, 255);
            while (kind >= cfg_type_lo && kind <= cfg_type_hi);
        end
        flags = (f == F_FLAGS) ? 16'd1 << $urandom_range(0, 15) : 16'd0;
        h = HASH_SEED;
        for (int i = 0; i < len && f != F_SIZE; i++) begin
            body = {body, 8'($urandom_range(0, 255))};
            h = hash_byte(h, body[i]);
        end
        if (f == F_HASH) h = h ^ (64'd1 << $urandom_range(0, 63));
        for (int i = 0; i < 4; i++) hdr[i] = magic[8*i +: 8];
        hdr[4] = ver;
        hdr[5] = kind;
        hdr[6] = flags[7:0];
        hdr[7] = flags[15:8];
        for (int i = 0; i < 4; i++) hdr[8 + i] = len[8*i +: 8];
        for (int i = 0; i < 8; i++) hdr[12 + i] = h[8*i +: 8];
        case (f)
            F_MAGIC:   upto = 4;
            F_VERSION: upto = 5;
            F_TYPE:    upto = 6;
            F_FLAGS:   upto = 8;
            F_SIZE:    upto = 12;
            default:   upto = 20;
        endcase
        for (int i = 0; i < upto; i++) pending_bytes = {pending_bytes, hdr[i]};
        if (upto == 20) foreach (body[i]) pending_bytes = {pending_bytes, body[i]};
    endtask

    task automatic random_traffic(input int budget);
        int r;
        int plen;
        while (pending_bytes.size() < budget) begin
            r = $urandom_range(0, 15);
            plen = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 8) : $urandom_range(9, 48);
            if (r < 8) make_frame(F_GOOD, plen);
            else if (r == 8) make_frame(F_HASH, plen);
            else if (r == 9) make_frame(F_MAGIC, plen);
            else if (r == 10) make_frame(F_VERSION, plen);
            else if (r == 11) make_frame(F_TYPE, plen);
            else if (r == 12) make_frame(F_FLAGS, plen);
            else if (r == 13) make_frame(F_SIZE, plen);
            else make_frame(F_NOISE, plen);
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: each header check against reset settings
        calm = 1'b1;
        make_frame(F_MAGIC, 0);
        make_frame(F_VERSION, 0);
        make_frame(F_TYPE, 0);
        make_frame(F_FLAGS, 0);
        wait_idle();
        make_frame(F_GOOD, 0);
        make_frame(F_HASH, 0);
        make_frame(F_GOOD, 3);
        make_frame(F_SIZE, 0);
        wait_idle();
        calm = 1'b0;

        for (int p = 0; p < 5; p++) begin
            case (p)
                0: begin
                    write_reg(REG_MAGIC, $urandom());
                    write_reg(REG_VERSION, $urandom_range(0, 255));
                    write_reg(REG_TYPE_LO, 0);
                    write_reg(REG_TYPE_HI, 8'hff);
                    write_reg(REG_LIMIT, 32'hffffffff);
                    calm = 1'b1;
                end
                1: begin
                    write_reg(REG_MAGIC, 32'hffffffff);
                    write_reg(REG_VERSION, 8'hff);
                    write_reg(REG_TYPE_LO, 10);
                    write_reg(REG_TYPE_HI, 20);
                    write_reg(REG_LIMIT, 30);
                    hold_requests++;
                end
                2: begin
                    write_reg(REG_MAGIC, 0);
                    write_reg(REG_VERSION, 0);
                    write_reg(REG_TYPE_LO, 200);
                    write_reg(REG_TYPE_HI, 100);
                    write_reg(REG_LIMIT, 0);
                    // out of range index must be ignored
                    write_reg(3'd7, $urandom());
                end
                3: begin
                    write_reg(REG_MAGIC, $urandom());
                    write_reg(REG_VERSION, $urandom_range(0, 255));
                    write_reg(REG_TYPE_LO, $urandom_range(0, 127));
                    write_reg(REG_TYPE_HI, $urandom_range(128, 255));
                    write_reg(REG_LIMIT, $urandom_range(0, 40));
                    hold_requests++;
                end
                default: begin
                    write_reg(REG_MAGIC, $urandom());
                    write_reg(REG_VERSION, $urandom_range(0, 255));
                    write_reg(REG_TYPE_LO, 8'hff);
                    write_reg(REG_TYPE_HI, 8'hff);
                    write_reg(REG_LIMIT, 8);
                end
            endcase
            random_traffic(270);
            wait_idle();
            calm = 1'b0;
        end

        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("Mismatches found");
        $finish;
    end
endmodule
`default_nettype wire

// File: files.f
+incdir+hdl
hdl/cfd_pkg.sv
hdl/cfd_front.sv
hdl/cfd_queue.sv
hdl/cfd_back.sv
hdl/checked_frame_deframer.sv
hdl/cfd_checker.sv
verif/checked_frame_deframer_test.sv
